// ===== rtl/gdad_pkg.sv =====
// Shared types, constants and calendar helpers for the date-plus-days unit.
// Used by gdad_front, gdad_fifo, gdad_back and gregorian_date_add_days_unit.
// No dependencies.
package gdad_pkg;

  // Fixed field widths of the stream payload.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DAYS_W  = 16;
  localparam int MOD_W   = 9;   // holds a year modulo 400

  // Month numbers used by the month step.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Gregorian cycle.
  localparam logic [MOD_W-1:0] CYCLE_LAST = 9'd399;
  localparam logic [YEAR_W-1:0] CYCLE_LEN = 14'd400;
  localparam logic [2:0] MOD_STEP_FIRST = 3'd5;  // 400 << 5 still fits 14 bits

  // Month lengths of a common year, January first.
  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_SUM,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

  // Status of the queue between the two halves.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Leap year judged from the year modulo 400.
  function automatic logic is_leap(input logic [MOD_W-1:0] r);
    logic div4;
    logic century;
    div4    = (r[1:0] == 2'd0);
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return div4 && !century;
  endfunction

  // Days in month m (1..12) with the given leap flag.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    logic [DAY_W-1:0]   len;
    idx = m - MONTH_JAN;
    if (m == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (idx < 4'd12) begin
      len = MONTH_LEN[idx];
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ===== rtl/gdad_front.sv =====
// Front half: accepts a start date, reduces the year modulo 400 and forms
// the day total from the start of the year, days to add included. Depends on gdad_pkg.
module gdad_front #(
  parameter int ADD_COUNT_BITS = 16,
  localparam int TOTAL_W = ADD_COUNT_BITS + 2,
  localparam int YR_W    = gdad_pkg::YEAR_W + ADD_COUNT_BITS / 8,
  localparam int PAY_W   = TOTAL_W + YR_W + gdad_pkg::MOD_W,
  localparam int ADD_IN_W = (ADD_COUNT_BITS < gdad_pkg::DAYS_W) ?
                            ADD_COUNT_BITS : gdad_pkg::DAYS_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gdad_pkg::DAY_W-1:0]        in_day,
  input  logic [gdad_pkg::MONTH_W-1:0]      in_month,
  input  logic [gdad_pkg::YEAR_W-1:0]       in_year,
  input  logic [gdad_pkg::DAYS_W-1:0]       in_days,
  input  gdad_pkg::fifo_status_t            fifo_st,
  output logic                              push,
  output logic [PAY_W-1:0]                  push_data
);

  gdad_pkg::front_state_t state, state_next;

  logic [TOTAL_W-1:0]               total;
  logic [gdad_pkg::YEAR_W-1:0]      year;
  logic [gdad_pkg::YEAR_W-1:0]      rem;
  logic [gdad_pkg::MONTH_W-1:0]     lead_months;
  logic [gdad_pkg::MONTH_W-1:0]     m_cnt;
  logic [2:0]                       k;
  logic [gdad_pkg::YEAR_W-1:0]      sub;
  logic                             leap;
  logic                             accept;

  assign accept = in_valid && in_ready;
  assign sub    = gdad_pkg::CYCLE_LEN << k;
  assign leap   = gdad_pkg::is_leap(rem[gdad_pkg::MOD_W-1:0]);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gdad_pkg::F_IDLE: if (in_valid) state_next = gdad_pkg::F_MOD;
      gdad_pkg::F_MOD:  if (k == 3'd0) state_next = gdad_pkg::F_SUM;
      gdad_pkg::F_SUM:  if (m_cnt > lead_months) state_next = gdad_pkg::F_PUSH;
      gdad_pkg::F_PUSH: if (!fifo_st.full) state_next = gdad_pkg::F_IDLE;
      default:          state_next = gdad_pkg::F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    case (state)
      gdad_pkg::F_IDLE: in_ready = 1'b1;
      gdad_pkg::F_PUSH: push = !fifo_st.full;
      default: begin
        in_ready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  assign push_data = {total, YR_W'(year), rem[gdad_pkg::MOD_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdad_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: capture, year reduction by shifted 400s, month-length sum.
  always_ff @(posedge clk) begin
    if (accept) begin
      year   <= in_year;
      rem    <= in_year;
      k      <= gdad_pkg::MOD_STEP_FIRST;
      m_cnt  <= gdad_pkg::MONTH_JAN;
      total  <= TOTAL_W'(in_day) + TOTAL_W'(in_days[ADD_IN_W-1:0]);
      if (in_month > gdad_pkg::MONTH_DEC) begin
        lead_months <= gdad_pkg::MONTH_DEC;
      end else if (in_month == 4'd0) begin
        lead_months <= 4'd0;
      end else begin
        lead_months <= in_month - gdad_pkg::MONTH_JAN;
      end
    end else if (state == gdad_pkg::F_MOD) begin
      if (rem >= sub) begin
        rem <= rem - sub;
      end
      k <= k - 3'd1;
    end else if (state == gdad_pkg::F_SUM && m_cnt <= lead_months) begin
      total <= total + TOTAL_W'(gdad_pkg::month_days(m_cnt, leap));
      m_cnt <= m_cnt + 4'd1;
    end
  end

endmodule

// ===== rtl/gdad_fifo.sv =====
// Two-entry queue between the front and back halves.
// Depends on gdad_pkg for the status struct.
module gdad_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       pop_data,
  output gdad_pkg::fifo_status_t st
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign st.full   = (count == 2'd2);
  assign st.empty  = (count == 2'd0);
  assign pop_data  = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/gdad_back.sv =====
// Back half: steps month by month through the remaining day total and
// holds the result beat in an output register. Depends on gdad_pkg.
module gdad_back #(
  parameter int ADD_COUNT_BITS = 16,
  localparam int TOTAL_W = ADD_COUNT_BITS + 2,
  localparam int YR_W    = gdad_pkg::YEAR_W + ADD_COUNT_BITS / 8,
  localparam int PAY_W   = TOTAL_W + YR_W + gdad_pkg::MOD_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gdad_pkg::fifo_status_t        fifo_st,
  input  logic [PAY_W-1:0]              pop_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gdad_pkg::DAY_W-1:0]    out_day,
  output logic [gdad_pkg::MONTH_W-1:0]  out_month,
  output logic [gdad_pkg::YEAR_W-1:0]   out_year
);

  gdad_pkg::back_state_t state, state_next;

  logic [TOTAL_W-1:0]            total;
  logic [YR_W-1:0]               year;
  logic [gdad_pkg::MOD_W-1:0]    ymod;
  logic [gdad_pkg::MONTH_W-1:0]  month;
  logic [gdad_pkg::DAY_W-1:0]    len;
  logic                          fits;
  logic                          load_out;

  assign len  = gdad_pkg::month_days(month, gdad_pkg::is_leap(ymod));
  assign fits = (total <= TOTAL_W'(len));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gdad_pkg::B_IDLE: if (!fifo_st.empty) state_next = gdad_pkg::B_RUN;
      gdad_pkg::B_RUN:  if (fits) state_next = gdad_pkg::B_DONE;
      gdad_pkg::B_DONE: if (!out_valid || out_ready) state_next = gdad_pkg::B_IDLE;
      default:          state_next = gdad_pkg::B_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      gdad_pkg::B_IDLE: pop = !fifo_st.empty;
      gdad_pkg::B_DONE: load_out = !out_valid || out_ready;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdad_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Month step: subtract the current month and advance, wrapping the year.
  always_ff @(posedge clk) begin
    if (pop) begin
      {total, year, ymod} <= pop_data;
      month <= gdad_pkg::MONTH_JAN;
    end else if (state == gdad_pkg::B_RUN && !fits) begin
      total <= total - TOTAL_W'(len);
      if (month == gdad_pkg::MONTH_DEC) begin
        month <= gdad_pkg::MONTH_JAN;
        year  <= year + YR_W'(1);
        ymod  <= (ymod == gdad_pkg::CYCLE_LAST) ? '0 : ymod + 9'd1;
      end else begin
        month <= month + 4'd1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_day   <= total[gdad_pkg::DAY_W-1:0];
      out_month <= month;
      out_year  <= year[gdad_pkg::YEAR_W-1:0];
    end
  end

endmodule

// ===== rtl/gregorian_date_add_days_unit.sv =====
// Flow: after a start date is accepted the front reduces the year (F_MOD), sums the
// lengths of the months before the start month (F_SUM) and writes the queue (F_PUSH); the
// back pops it (B_IDLE), steps month by month until the total fits (B_RUN) and loads the result (B_DONE).
// The front takes a new start date only once it has queued the last one; the back-half
// month loop limits the flow for long counts, the front half for short ones.
// Reset: rst is synchronous, active high, and empties the queue and both halves.
module gregorian_date_add_days_unit #(
  parameter int ADD_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23], zero[39]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_day[4:0], result_month[8:5], result_year[22:9], zero[23]
  output logic [23:0] m_axis_tdata
);

  localparam int TOTAL_W = ADD_COUNT_BITS + 2;
  localparam int YR_W    = gdad_pkg::YEAR_W + ADD_COUNT_BITS / 8;
  localparam int PAY_W   = TOTAL_W + YR_W + gdad_pkg::MOD_W;

  gdad_pkg::fifo_status_t             fifo_st;
  logic                               push;
  logic                               pop;
  logic [PAY_W-1:0]                   push_data;
  logic [PAY_W-1:0]                   pop_data;
  logic [gdad_pkg::DAY_W-1:0]         res_day;
  logic [gdad_pkg::MONTH_W-1:0]       res_month;
  logic [gdad_pkg::YEAR_W-1:0]        res_year;

  gdad_front #(.ADD_COUNT_BITS(ADD_COUNT_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_day    (s_axis_tdata[4:0]),
    .in_month  (s_axis_tdata[8:5]),
    .in_year   (s_axis_tdata[22:9]),
    .in_days   (s_axis_tdata[38:23]),
    .fifo_st   (fifo_st),
    .push      (push),
    .push_data (push_data)
  );

  gdad_fifo #(.WIDTH(PAY_W)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .st        (fifo_st)
  );

  gdad_back #(.ADD_COUNT_BITS(ADD_COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_st   (fifo_st),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_day   (res_day),
    .out_month (res_month),
    .out_year  (res_year)
  );

  assign m_axis_tdata = {1'b0, res_year, res_month, res_day};

  // The front never writes a full queue, and the back never reads an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_st.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_st.empty)
    else $error("queue read while empty");

  // A result month is always a real month.
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[8:5] >= 4'd1 && m_axis_tdata[8:5] <= 4'd12))
    else $error("result month out of range");

  // The front takes one start date at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("front accepted back to back");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for gregorian_date_add_days_unit: start dates and day counts
// stream in, each resulting date is predicted here and compared on the way out.
// Depends on gdad_pkg and the unit RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DAY_W   = gdad_pkg::DAY_W;
  localparam int MONTH_W = gdad_pkg::MONTH_W;
  localparam int YEAR_W  = gdad_pkg::YEAR_W;
  localparam int DAYS_W  = gdad_pkg::DAYS_W;

  localparam int ADD_BITS     = 16;
  localparam int RANDOM_ITEMS = 248;
  localparam int TAIL_ITEMS   = 30;
  localparam int unsigned COMMON_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Input beat layout, last field in the low bits.
  typedef struct packed {
    logic [DAYS_W-1:0]  count;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_req_t;

  // Result beat layout, last field in the low bits.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23], zero[39]
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // result_day[4:0], result_month[8:5], result_year[22:9], zero[23]
  logic [23:0] m_axis_tdata;

  date_req_t pending_reqs[$];
  date_res_t expected_dates[$];
  date_req_t in_flight;
  int items_total    = 0;
  int items_accepted = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int src_gap        = 0;
  int sink_gap       = 0;
  int src_idle_pct   = 20;
  int sink_idle_pct  = 20;

  gregorian_date_add_days_unit #(
    .ADD_COUNT_BITS(ADD_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Leap year on the full, unwrapped year.
  function automatic bit leap_gregorian(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Length of month mon (1..12) in year yr.
  function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
    if (mon == 2) begin
      return leap_gregorian(yr) ? 29 : 28;
    end
    return COMMON_LEN[(mon - 1) % 12];
  endfunction

  // Date reached by moving count days forward from the start date.
  function automatic date_res_t advance_date(input date_req_t rq);
    int unsigned yr;
    int unsigned rem;
    int unsigned mon;
    int unsigned lead;
    int unsigned len;
    date_res_t   res;
    yr  = rq.year;
    rem = rq.day + (rq.count & ((32'd1 << ADD_BITS) - 1));
    // Months before the start month; out-of-range months clamp to none or all.
    lead = (rq.month > 12) ? 12 : ((rq.month == 0) ? 0 : rq.month - 1);
    for (int unsigned k = 1; k <= lead; k++) begin
      rem += month_length(k, yr);
    end
    // Walk forward from January of the start year.
    mon = 1;
    len = month_length(mon, yr);
    while (rem > len) begin
      rem -= len;
      mon++;
      if (mon > 12) begin
        mon = 1;
        yr++;
      end
      len = month_length(mon, yr);
    end
    res.day   = DAY_W'(rem);
    res.month = MONTH_W'(mon);
    res.year  = YEAR_W'(yr);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic add_date_req(input int unsigned d, input int unsigned m,
                              input int unsigned y, input int unsigned n);
    date_req_t rq;
    rq.day   = DAY_W'(d);
    rq.month = MONTH_W'(m);
    rq.year  = YEAR_W'(y);
    rq.count = DAYS_W'(n);
    pending_reqs.push_back(rq);
  endtask

  // Compare one result beat with the oldest predicted date.
  task automatic check_result(input date_res_t got);
    date_res_t want;
    string     diffs;
    results_seen++;
    if (expected_dates.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0d/%0d arrived with nothing expected",
                                got.day, got.month, got.year));
    end else begin
      want  = expected_dates.pop_front();
      diffs = "";
      if (got.day != want.day) begin
        diffs = {diffs, $sformatf(" day got %0d want %0d", got.day, want.day)};
      end
      if (got.month != want.month) begin
        diffs = {diffs, $sformatf(" month got %0d want %0d", got.month, want.month)};
      end
      if (got.year != want.year) begin
        diffs = {diffs, $sformatf(" year got %0d want %0d", got.year, want.year)};
      end
      if (diffs != "") begin
        report_mismatch($sformatf("result %0d:%s", results_seen, diffs));
      end
    end
  endtask

  // Source side: present queued requests, record a prediction per accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.push_back(advance_date(in_flight));
        items_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_flight = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, in_flight};
          items_sent++;
          // Change the idle density now and then, including stretches with none.
          if (items_sent % 25 == 0) begin
            case ($urandom_range(2))
              0: src_idle_pct = 0;
              1: src_idle_pct = 20;
              default: src_idle_pct = 50;
            endcase
          end
          if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(99) < src_idle_pct) begin
            src_gap = $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each accepted result beat and stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(date_res_t'(m_axis_tdata[22:0]));
        if (results_seen % 25 == 0) begin
          case ($urandom_range(2))
            0: sink_idle_pct = 0;
            1: sink_idle_pct = 25;
            default: sink_idle_pct = 50;
          endcase
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (results_seen + TAIL_ITEMS < items_total && $urandom_range(99) < sink_idle_pct) begin
          sink_gap = $urandom_range(1, 10);
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    date_req_t rq;
    int        sel;
    int        long_counts;
    int        odd_starts;
    long_counts = 0;
    odd_starts  = 0;

    // Extremes of every field.
    add_date_req(1, 1, 0, 0);
    add_date_req(31, 12, 9999, 65535);
    add_date_req(1, 1, 2000, 65535);
    add_date_req(31, 15, 16383, 65535);
    add_date_req(16, 10, 10922, 21845);
    // Leap rules: leap February, century year, 400-year cycle, plain leap year.
    add_date_req(29, 2, 2000, 0);
    add_date_req(28, 2, 1900, 1);
    add_date_req(28, 2, 2000, 1);
    add_date_req(28, 2, 2004, 1);
    add_date_req(1, 3, 2100, 365);
    add_date_req(15, 6, 1600, 36524);
    // Impossible start days carried into later months.
    add_date_req(31, 2, 2023, 0);
    add_date_req(30, 2, 2024, 5);
    add_date_req(31, 4, 2019, 0);
    // Zero total and zero day.
    add_date_req(0, 0, 500, 0);
    add_date_req(0, 1, 500, 0);
    add_date_req(0, 7, 2399, 0);
    // Month zero and months above twelve.
    add_date_req(5, 0, 2020, 10);
    add_date_req(31, 13, 2020, 0);
    // Year rollover and wrap of the 14-bit year.
    add_date_req(31, 12, 1999, 1);
    add_date_req(31, 12, 16383, 1);
    add_date_req(1, 1, 8192, 1461);

    // Random part: mostly real dates with mostly short counts.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        rq.year  = YEAR_W'($urandom_range(9999));
        rq.month = MONTH_W'($urandom_range(1, 12));
        rq.day   = DAY_W'($urandom_range(1, month_length(rq.month, rq.year)));
      end else if (sel < 85) begin
        // Close to the top of the year field, so the result can wrap.
        rq.year  = YEAR_W'($urandom_range(16000, 16383));
        rq.month = MONTH_W'($urandom_range(1, 12));
        rq.day   = DAY_W'($urandom_range(1, 31));
      end else begin
        // Any value the fields can hold.
        rq.year  = YEAR_W'($urandom_range(16383));
        rq.month = MONTH_W'($urandom_range(15));
        rq.day   = DAY_W'($urandom_range(31));
        odd_starts++;
      end
      sel = $urandom_range(99);
      if (sel < 60) begin
        rq.count = DAYS_W'($urandom_range(400));
      end else if (sel < 80) begin
        rq.count = DAYS_W'($urandom_range(4000));
      end else if (sel < 92) begin
        rq.count = DAYS_W'($urandom_range(65535));
      end else begin
        rq.count = DAYS_W'($urandom_range(65000, 65535));
      end
      if (rq.count > 10000) begin
        long_counts++;
      end
      pending_reqs.push_back(rq);
    end
    items_total = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < items_total) @(posedge clk);
    repeat (2) @(posedge clk);
    while (expected_dates.size() > 0) @(posedge clk);
    // Room for any stray result after the last expected one.
    repeat (60) @(posedge clk);

    $display("Run covered %0d date requests (%0d counts above 10000 days, %0d unusual starts).",
             items_total, long_counts, odd_starts);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS gregorian_date_add_days_unit");
    end else begin
      $display("FAIL gregorian_date_add_days_unit");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("Timeout: results still outstanding at the run limit.");
    $display("FAIL gregorian_date_add_days_unit");
    $finish;
  end

endmodule
